[hw/rtl/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`endif

[hw/rtl/fmt_pkg.sv]
package fmt_pkg;
  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_NEW = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_OUT = 2'd1;
  localparam logic [1:0] DIR_IN = 2'd2;
  localparam logic [1:0] DIR_LOCAL = 2'd3;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [0:0] CFG_MASK = 1'b0;
  localparam logic [0:0] CFG_ADDR = 1'b1;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic [7:0]  flags;
    logic [15:0] payload_bytes;
    logic [31:0] time_sec;
    logic [19:0] time_usec;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  direction;
    logic [31:0] packets;
    logic [47:0] bytes;
    logic [15:0] min_size;
    logic [15:0] max_size;
    logic [47:0] gap_sum_us;
    logic [31:0] syn_seen;
    logic [31:0] ack_seen;
    logic [31:0] fin_seen;
    logic [31:0] rst_seen;
  } rec_t;

  // stored flow entry (one memory word)
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [7:0]  proto;
    logic [1:0]  dir;
    logic [31:0] packets;
    logic [47:0] bytes;
    logic [15:0] min_size;
    logic [15:0] max_size;
    logic [31:0] last_sec;
    logic [19:0] last_usec;
    logic [47:0] gap_sum;
    logic [31:0] syn;
    logic [31:0] ack;
    logic [31:0] fin;
    logic [31:0] rst;
  } entry_t;
endpackage

[hw/rtl/fmt_pkt_if.sv]
interface fmt_pkt_if;
  import fmt_pkg::*;
  logic valid;
  logic ready;
  pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/fmt_rec_if.sv]
interface fmt_rec_if;
  import fmt_pkg::*;
  logic valid;
  logic ready;
  rec_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/flow_metering_table_core.sv]
// Channel   Dir  Payload                            Beat when
// pkt       in   5-tuple, flags, size, timestamp    pkt.valid & pkt.ready
// rec       out  status, direction, flow counters   rec.valid & rec.ready
// cfg       in   cfg_we / cfg_index / cfg_data      cfg_we high
// Each used entry costs a read issue, then a key compare on the
// registered read data. After accept, a hit goes scan, compare, gap, update,
// output; a new flow goes scan, update, output; a full table drops at scan.
// Reset clears the fill count, LAN config and FSM, not the table; no clearing
// pass; entries past the count are unused. The record waits in the output
// register; the next packet is accepted the cycle after the record is taken.
module flow_metering_table_core #(
  parameter int FLOW_ENTRIES = 1024
) (
  input  logic clk,
  input  logic rst,
  fmt_pkt_if.sink   pkt,
  fmt_rec_if.source rec,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import fmt_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CW = $clog2(FLOW_ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_GAP  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [31:0] lan_mask, lan_addr;
  logic [CW-1:0] entries_used;
  logic [CW-1:0] scan_idx;
  pkt_t cur;
  entry_t mem [FLOW_ENTRIES];
  entry_t rd_q;
  entry_t wr_e;
  logic wr_en;
  logic [AW-1:0] hit_idx;
  logic is_new;
  logic [52:0] gap;   // signed-style: bit 52 set means negative
  rec_t out_q;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      lan_mask <= '0;
      lan_addr <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MASK: lan_mask <= cfg_data;
        CFG_ADDR: lan_addr <= cfg_data;
        default: ;
      endcase
    end
  end

  // table memory: one read, one write port
  always_ff @(posedge clk) begin
    rd_q <= mem[state == S_UPD ? hit_idx : scan_idx[AW-1:0]];
    if (wr_en) mem[hit_idx] <= wr_e;
  end

  assign pkt.ready = (state == S_IDLE) && !out_valid;
  assign rec.valid = out_valid;
  assign rec.data = out_q;

  logic key_match;
  assign key_match = rd_q.src == cur.src_addr && rd_q.dst == cur.dst_addr &&
    rd_q.ports == {cur.sport, cur.dport} && rd_q.proto == cur.protocol;

  function automatic logic [1:0] classify(logic [31:0] s, logic [31:0] d,
                                          logic [31:0] m, logic [31:0] n);
    logic sl, dl;
    sl = (s & m) == n;
    dl = (d & m) == n;
    if (m == '0) return DIR_NONE;
    if (sl && !dl) return DIR_OUT;
    if (!sl && dl) return DIR_IN;
    if (sl && dl) return DIR_LOCAL;
    return DIR_NONE;
  endfunction

  function automatic logic [31:0] inc32(logic [31:0] v, logic en);
    return (en && v != '1) ? v + 32'd1 : v;
  endfunction

  // update datapath
  entry_t upd;
  logic [48:0] bsum, gsum;
  logic tcp;
  always_comb begin
    upd = rd_q;
    tcp = cur.protocol == PROTO_TCP;
    bsum = {1'b0, rd_q.bytes} + 49'(cur.payload_bytes);
    gsum = {1'b0, rd_q.gap_sum} + {1'b0, gap[47:0]};
    if (is_new) begin
      upd.src = cur.src_addr;
      upd.dst = cur.dst_addr;
      upd.ports = {cur.sport, cur.dport};
      upd.proto = cur.protocol;
      upd.dir = classify(cur.src_addr, cur.dst_addr, lan_mask, lan_addr);
      upd.packets = 32'd1;
      upd.bytes = 48'(cur.payload_bytes);
      upd.gap_sum = '0;
      upd.min_size = cur.payload_bytes;
      upd.max_size = cur.payload_bytes;
      upd.syn = 32'(tcp & cur.flags[1]);
      upd.ack = 32'(tcp & cur.flags[4]);
      upd.fin = 32'(tcp & cur.flags[0]);
      upd.rst = 32'(tcp & cur.flags[2]);
    end else begin
      if (cur.payload_bytes < rd_q.min_size) upd.min_size = cur.payload_bytes;
      if (cur.payload_bytes > rd_q.max_size) upd.max_size = cur.payload_bytes;
      // gap positive and nonzero adds; upper bits beyond 48 saturate
      if (!gap[52] && gap[51:0] != '0) begin
        if (gap[51:48] != '0 || gsum[48]) upd.gap_sum = '1;
        else upd.gap_sum = gsum[47:0];
      end
      upd.packets = inc32(rd_q.packets, 1'b1);
      upd.bytes = bsum[48] ? '1 : bsum[47:0];
      upd.syn = inc32(rd_q.syn, tcp & cur.flags[1]);
      upd.ack = inc32(rd_q.ack, tcp & cur.flags[4]);
      upd.fin = inc32(rd_q.fin, tcp & cur.flags[0]);
      upd.rst = inc32(rd_q.rst, tcp & cur.flags[2]);
    end
    upd.last_sec = cur.time_sec;
    upd.last_usec = cur.time_usec;
  end

  // gap = (sec - last_sec) * 1e6 + (usec - last_usec), 53-bit two's complement
  logic [52:0] dsec_prod;
  always_comb begin
    dsec_prod = 53'($signed({1'b0, cur.time_sec}) - $signed({1'b0, rd_q.last_sec}))
              * 53'(USEC_PER_SEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entries_used <= '0;
      out_valid <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      // out_valid is low in every state but idle, so this never meets a set
      if (out_valid && rec.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (pkt.valid && pkt.ready) begin
          cur <= pkt.data;
          scan_idx <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // read issued at scan_idx; compare next cycle
          if (scan_idx >= entries_used) begin
            if (entries_used >= CW'(FLOW_ENTRIES)) begin
              out_q <= '{status: ST_FULL, default: '0};
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              hit_idx <= entries_used[AW-1:0];
              is_new <= 1'b1;
              state <= S_UPD;
            end
          end else state <= S_CMP;
        end
        S_CMP: begin
          if (key_match) begin
            hit_idx <= scan_idx[AW-1:0];
            is_new <= 1'b0;
            state <= S_GAP;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_GAP: begin
          gap <= dsec_prod + 53'($signed({1'b0, cur.time_usec})
                 - $signed({1'b0, rd_q.last_usec}));
          state <= S_UPD;
        end
        S_UPD: begin
          wr_e <= upd;
          wr_en <= 1'b1;
          if (is_new) entries_used <= entries_used + 1'b1;
          out_q.status <= is_new ? ST_NEW : ST_HIT;
          out_q.direction <= upd.dir;
          out_q.packets <= upd.packets;
          out_q.bytes <= upd.bytes;
          out_q.min_size <= upd.min_size;
          out_q.max_size <= upd.max_size;
          out_q.gap_sum_us <= upd.gap_sum;
          out_q.syn_seen <= upd.syn;
          out_q.ack_seen <= upd.ack;
          out_q.fin_seen <= upd.fin;
          out_q.rst_seen <= upd.rst;
          state <= S_OUT;
        end
        S_OUT: begin
          // write lands this cycle
          wr_en <= 1'b0;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_used_bound, 1'b1, entries_used <= CW'(FLOW_ENTRIES))
  `ASSERT_NEXT(a_wr_after_upd, state == S_UPD, wr_en)
  `ASSERT_IMPL(a_no_accept_busy, state != S_IDLE, !pkt.ready)
  `ASSERT_NEXT(a_hold_out, out_valid && !rec.ready, out_valid && $stable(out_q))
endmodule
